// ===== rtl/core/sic_pkg.sv =====
`default_nettype none
package sic_pkg;

  // Cache geometry (SET_COUNT must be a power of two)
  localparam int SET_COUNT   = 64;
  localparam int WAY_COUNT   = 4;
  localparam int MAX_LEN     = 64;
  localparam int HANDLE_BITS = 16;

  localparam int SET_BITS     = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
  localparam int WAY_BITS     = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
  localparam int CNT_BITS     = $clog2(WAY_COUNT + 1);
  localparam int LEN_BITS     = $clog2(MAX_LEN + 1);
  localparam int IDX_BITS     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int SLOT_BITS    = SET_BITS + WAY_BITS;
  localparam int SLOT_DEPTH   = 1 << SLOT_BITS;
  localparam int TEXT_DEPTH   = SLOT_DEPTH << IDX_BITS;
  localparam int META_DEPTH   = 1 << SET_BITS;

  localparam logic [31:0] HASH_SEED = 32'd5381;

  typedef enum logic [1:0] {
    OUT_HIT      = 2'd0,
    OUT_MISS     = 2'd1,
    OUT_TOO_LONG = 2'd2
  } outcome_t;

  // Per-set record: number of valid ways and logical-to-physical way order
  typedef struct packed {
    logic [CNT_BITS-1:0]                    cnt;
    logic [WAY_COUNT-1:0][WAY_BITS-1:0]     ord;
  } meta_t;

  typedef struct packed {
    logic [LEN_BITS-1:0]    len;
    logic [HANDLE_BITS-1:0] handle;
  } slot_t;

  function automatic logic [31:0] mix_byte(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] prod;
    prod = (h << 5) + h;
    return prod ^ {{24{b[7]}}, b};
  endfunction

  function automatic logic [WAY_COUNT-1:0][WAY_BITS-1:0] ident_order();
    logic [WAY_COUNT-1:0][WAY_BITS-1:0] o;
    for (int w = 0; w < WAY_COUNT; w++) begin
      o[w] = WAY_BITS'(w);
    end
    return o;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/sic_if.sv =====
`default_nettype none
interface sic_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  char_byte;
  logic        has_byte;
  logic        last;
  logic [15:0] new_handle;
  modport source (output valid, char_byte, has_byte, last, new_handle, input ready);
  modport sink (input valid, char_byte, has_byte, last, new_handle, output ready);
endinterface

interface sic_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  outcome;
  logic [15:0] result_handle;
  logic [31:0] hash_value;
  modport source (output valid, outcome, result_handle, hash_value, input ready);
  modport sink (input valid, outcome, result_handle, hash_value, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/string_intern_cache.sv =====
`default_nettype none
// Channel  | Dir | Payload                                    | Transfer
// req      | in  | char_byte, has_byte, last, new_handle      | valid && ready
// rsp      | out | outcome, result_handle, hash_value         | valid && ready
//
// A byte item is taken while idle. A closing item reads the set record, then per
// way probed reads the slot record and compares the bytes one at a time
// (text and input buffer memories read in lockstep), and on a miss writes the
// records and, for a non-empty string, copies the text into the victim way
// through the buffer read port.
// After reset a clearing pass initializes the set records; req is held off until
// it ends. A result waiting on rsp stalls req only.
module string_intern_cache (
  input wire logic  clk,
  input wire logic  rst,
  sic_in_if.sink    req,
  sic_out_if.source rsp
);
  import sic_pkg::*;

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_META  = 7'b0000100,
    ST_SLOT  = 7'b0001000,
    ST_CMP   = 7'b0010000,
    ST_MISS  = 7'b0100000,
    ST_COPY  = 7'b1000000
  } state_t;

  state_t state;

  // Running string state
  logic [31:0]            hash;
  logic [LEN_BITS-1:0]    len;
  logic                   too_long;
  logic [HANDLE_BITS-1:0] handle_q;
  logic [SET_BITS-1:0]    set_q;
  meta_t                  meta_q;
  logic [CNT_BITS-1:0]    way;
  logic [IDX_BITS-1:0]    idx;
  logic [LEN_BITS-1:0]    cp;
  logic [HANDLE_BITS-1:0] hit_handle;
  logic [SET_BITS-1:0]    clr_addr;

  // Output register
  logic                   out_valid;
  outcome_t               out_outcome;
  logic [HANDLE_BITS-1:0] out_handle;
  logic [31:0]            out_hash;

  // Memory ports
  logic                  meta_we;
  logic [SET_BITS-1:0]   meta_waddr, meta_raddr;
  meta_t                 meta_wdata, meta_rdata;
  logic                  slot_we;
  logic [SLOT_BITS-1:0]  slot_waddr, slot_raddr;
  slot_t                 slot_wdata, slot_rdata;
  logic                  text_we;
  logic [SLOT_BITS+IDX_BITS-1:0] text_waddr, text_raddr;
  logic [7:0]            text_rdata;
  logic                  inc_we;
  logic [IDX_BITS-1:0]   inc_waddr, inc_raddr;
  logic [7:0]            inc_rdata;

  // Accept-time byte handling
  logic                  in_fire;
  logic                  take_byte, store_byte, too_long_next;
  logic [31:0]           hash_next;
  logic [CNT_BITS-1:0]   way_inc;
  logic [WAY_BITS-1:0]   victim;
  logic [IDX_BITS-1:0]   idx_inc;
  logic                  len_match, last_byte, way_end;

  assign req.ready = (state == ST_IDLE) && (!out_valid || rsp.ready);
  assign in_fire   = req.valid && req.ready;

  assign take_byte     = req.has_byte && !too_long;
  assign store_byte    = take_byte && (len < LEN_BITS'(MAX_LEN));
  assign too_long_next = too_long || (take_byte && !store_byte);
  assign hash_next     = store_byte ? mix_byte(hash, req.char_byte) : hash;

  assign way_inc   = way + CNT_BITS'(1);
  assign way_end   = (way_inc == meta_q.cnt);
  assign victim    = meta_q.ord[WAY_COUNT-1];
  assign idx_inc   = idx + IDX_BITS'(1);
  assign len_match = (slot_rdata.len == len);
  assign last_byte = ((LEN_BITS'(idx) + LEN_BITS'(1)) == len);

  // Set record: cleared after reset, rewritten on a miss with the victim rotated to way 0
  always_comb begin
    meta_we    = 1'b0;
    meta_waddr = set_q;
    meta_wdata.cnt = '0;
    meta_wdata.ord = ident_order();
    if (state == ST_CLEAR) begin
      meta_we    = 1'b1;
      meta_waddr = clr_addr;
    end else if (state == ST_MISS) begin
      meta_we = 1'b1;
      meta_wdata.cnt = (meta_q.cnt == CNT_BITS'(WAY_COUNT)) ? meta_q.cnt
                                                            : meta_q.cnt + CNT_BITS'(1);
      meta_wdata.ord[0] = victim;
      for (int w = 1; w < WAY_COUNT; w++) begin
        meta_wdata.ord[w] = meta_q.ord[w-1];
      end
    end
  end
  assign meta_raddr = hash_next[SET_BITS-1:0];

  // Slot record: read first way from fresh set record, later ways from the latched one
  assign slot_raddr = (state == ST_META) ? {set_q, meta_rdata.ord[0]}
                                         : {set_q, meta_q.ord[way_inc[WAY_BITS-1:0]]};
  assign slot_we          = (state == ST_MISS);
  assign slot_waddr       = {set_q, victim};
  assign slot_wdata.len    = len;
  assign slot_wdata.handle = handle_q;

  // Text compare streams byte idx+1 while byte idx is checked
  assign text_raddr = {set_q, meta_q.ord[way[WAY_BITS-1:0]],
                       (state == ST_CMP) ? idx_inc : IDX_BITS'(0)};
  assign inc_raddr  = (state == ST_CMP)  ? idx_inc :
                      (state == ST_COPY) ? cp[IDX_BITS-1:0] : IDX_BITS'(0);
  assign inc_we     = in_fire && store_byte;
  assign inc_waddr  = len[IDX_BITS-1:0];

  // Copy writes each byte in the cycle after its buffer read
  logic [LEN_BITS-1:0] cp_prev;
  assign cp_prev    = cp - LEN_BITS'(1);
  assign text_we    = (state == ST_COPY) && (cp != '0);
  assign text_waddr = {set_q, victim, cp_prev[IDX_BITS-1:0]};

  sic_ram #(.WIDTH($bits(meta_t)), .DEPTH(META_DEPTH)) u_meta (
    .clk(clk), .we(meta_we), .waddr(meta_waddr), .wdata(meta_wdata),
    .raddr(meta_raddr), .rdata(meta_rdata)
  );
  sic_ram #(.WIDTH($bits(slot_t)), .DEPTH(SLOT_DEPTH)) u_slot (
    .clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
    .raddr(slot_raddr), .rdata(slot_rdata)
  );
  sic_ram #(.WIDTH(8), .DEPTH(TEXT_DEPTH)) u_text (
    .clk(clk), .we(text_we), .waddr(text_waddr), .wdata(inc_rdata),
    .raddr(text_raddr), .rdata(text_rdata)
  );
  sic_ram #(.WIDTH(8), .DEPTH(1 << IDX_BITS)) u_inc (
    .clk(clk), .we(inc_we), .waddr(inc_waddr), .wdata(req.char_byte),
    .raddr(inc_raddr), .rdata(inc_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      hash      <= HASH_SEED;
      len       <= '0;
      too_long  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // Drop the result once transferred
      if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + SET_BITS'(1);
          if (clr_addr == SET_BITS'(SET_COUNT - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_fire) begin
            hash     <= hash_next;
            too_long <= too_long_next;
            if (store_byte) begin
              len <= len + LEN_BITS'(1);
            end
            if (req.last) begin
              handle_q <= req.new_handle[HANDLE_BITS-1:0];
              set_q    <= hash_next[SET_BITS-1:0];
              if (too_long_next) begin
                // Bypass: report and restart
                out_valid   <= 1'b1;
                out_outcome <= OUT_TOO_LONG;
                out_handle  <= req.new_handle[HANDLE_BITS-1:0];
                out_hash    <= '0;
                hash        <= HASH_SEED;
                len         <= '0;
                too_long    <= 1'b0;
              end else begin
                state <= ST_META;
              end
            end
          end
        end
        ST_META: begin
          meta_q <= meta_rdata;
          way    <= '0;
          state  <= (meta_rdata.cnt == '0) ? ST_MISS : ST_SLOT;
        end
        ST_SLOT: begin
          if (len_match && (len == '0)) begin
            out_valid   <= 1'b1;
            out_outcome <= OUT_HIT;
            out_handle  <= slot_rdata.handle;
            out_hash    <= hash;
            hash        <= HASH_SEED;
            state       <= ST_IDLE;
          end else if (len_match) begin
            hit_handle <= slot_rdata.handle;
            idx        <= '0;
            state      <= ST_CMP;
          end else if (way_end) begin
            state <= ST_MISS;
          end else begin
            way <= way_inc;
          end
        end
        ST_CMP: begin
          if (text_rdata != inc_rdata) begin
            // Advance to next way or give up
            if (way_end) begin
              state <= ST_MISS;
            end else begin
              way   <= way_inc;
              state <= ST_SLOT;
            end
          end else if (last_byte) begin
            out_valid   <= 1'b1;
            out_outcome <= OUT_HIT;
            out_handle  <= hit_handle;
            out_hash    <= hash;
            hash        <= HASH_SEED;
            len         <= '0;
            state       <= ST_IDLE;
          end else begin
            idx <= idx_inc;
          end
        end
        ST_MISS: begin
          out_valid   <= 1'b1;
          out_outcome <= OUT_MISS;
          out_handle  <= handle_q;
          out_hash    <= hash;
          hash        <= HASH_SEED;
          cp          <= '0;
          state       <= (len == '0) ? ST_IDLE : ST_COPY;
        end
        ST_COPY: begin
          cp <= cp + LEN_BITS'(1);
          if (cp == len) begin
            len   <= '0;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.outcome       = out_outcome;
  assign rsp.result_handle = 16'(out_handle);
  assign rsp.hash_value    = out_hash;

endmodule
`default_nettype wire

// ===== rtl/core/sic_ram.sv =====
`default_nettype none
module sic_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire
